/* rtl/dsfp_pkg.sv */
// Shared types and constants for the dust sensor frame parser.
package dsfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned VALUE_W = 15;

  // Frame byte positions
  localparam logic [POS_W-1:0] POS_START = 4'd0;
  localparam logic [POS_W-1:0] POS_ID    = 4'd1;
  localparam logic [POS_W-1:0] POS_HIGH  = 4'd3;
  localparam logic [POS_W-1:0] POS_LOW   = 4'd4;
  localparam logic [POS_W-1:0] POS_CSUM  = 4'd8;

  localparam logic [BYTE_W-1:0] FRAME_START = 8'hFF;
  localparam logic [BYTE_W-1:0] FRAME_ID    = 8'h18;
  localparam logic [6:0]        HIGH_WEIGHT = 7'd100;

  typedef struct packed {
    logic               vld;
    logic [VALUE_W-1:0] value;
  } dsfp_result_t;

endpackage

/* rtl/dsfp_frame_fsm.sv */
// Frame position tracking, checksum accumulation and reading computation.
module dsfp_frame_fsm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [dsfp_pkg::BYTE_W-1:0]  rx_byte,
  output dsfp_pkg::dsfp_result_t       res
);
  import dsfp_pkg::*;

  logic [POS_W-1:0]  pos_r,  pos_nxt;
  logic [BYTE_W-1:0] sum_r,  sum_nxt;
  logic [BYTE_W-1:0] high_r, high_nxt;
  logic [BYTE_W-1:0] low_r,  low_nxt;
  logic [VALUE_W-1:0] value;
  logic               csum_ok;

  // reading = high * 100 + low, max 25755
  assign value   = VALUE_W'(high_r) * VALUE_W'(HIGH_WEIGHT) + VALUE_W'(low_r);
  assign csum_ok = (BYTE_W'(rx_byte + sum_r) == '0);

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    res.vld   = 1'b0;
    res.value = value;
    if (step) begin
      priority if (pos_r == POS_START) begin
        if (rx_byte == FRAME_START) begin
          pos_nxt = POS_ID;
        end else begin
          pos_nxt  = POS_START;
          sum_nxt  = '0;
          high_nxt = '0;
          low_nxt  = '0;
        end
      end else if (pos_r == POS_ID) begin
        if (rx_byte == FRAME_ID) begin
          sum_nxt = rx_byte;
          pos_nxt = POS_ID + POS_W'(1);
        end else begin
          pos_nxt  = POS_START;
          sum_nxt  = '0;
          high_nxt = '0;
          low_nxt  = '0;
        end
      end else if (pos_r < POS_CSUM) begin
        sum_nxt = sum_r + rx_byte;
        if (pos_r == POS_HIGH) high_nxt = rx_byte;
        if (pos_r == POS_LOW)  low_nxt  = rx_byte;
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        // checksum byte, or an out-of-range position: back to start
        res.vld  = (pos_r == POS_CSUM) && csum_ok;
        pos_nxt  = POS_START;
        sum_nxt  = '0;
        high_nxt = '0;
        low_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_START;
      sum_r  <= '0;
      high_r <= '0;
      low_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_CSUM)
    else $error("frame position out of range");

  a_res_at_csum: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> (step && pos_r == POS_CSUM))
    else $error("result outside checksum byte");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (step && pos_r == POS_CSUM) |=> pos_r == POS_START)
    else $error("position did not wrap after checksum");

  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == POS_ID |-> sum_r == '0)
    else $error("checksum not cleared at frame start");

endmodule

/* rtl/dsfp_out_reg.sv */
// Result register that holds a reading until the downstream side takes it.
module dsfp_out_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dsfp_pkg::dsfp_result_t          res,
  output logic                            adv,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dsfp_pkg::VALUE_W-1:0]    out_value
);
  import dsfp_pkg::*;

  logic               vld_r;
  logic [VALUE_W-1:0] value_r;

  // slot free or being drained this cycle
  assign adv        = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_value  = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      value_r <= res.value;
    end
  end

endmodule

/* rtl/dust_sensor_frame_parser_core.sv */
// Top level: dust sensor frame parser, byte stream in, reading stream out.
// Path: a byte passes the input register, then the result register.
// Throughput: one byte per cycle unless the reading side stalls; the result register
//   lets the next byte enter while a reading waits; the parse step runs when it frees.
// Reset: rst_n synchronous active low; clears position, checksum, readings and
//   both valid flags. No clearing pass; in_tready is high once reset is released.
module dust_sensor_frame_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // reading stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [14:0] pm25_value, [15] zero
);
  import dsfp_pkg::*;

  logic               in_vld_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic               adv;
  logic               step;
  dsfp_result_t       res;
  logic [VALUE_W-1:0] out_value;

  // Parse step runs when a byte is staged and the result slot can take
  // whatever it produces.
  assign step      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  dsfp_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  dsfp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_value)
  );

  // pad to a whole number of bytes
  assign out_tdata = {1'b0, out_value};

endmodule

/* dv/tb_dust_sensor_frame_parser_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the dust sensor frame parser core.
module tb_dust_sensor_frame_parser_core;
  import dsfp_pkg::*;

  localparam int CLK_HALF       = 2;     // 4 ns period
  localparam int RESET_CYCLES   = 8;
  localparam int IDLE_PCT       = 8;     // idle rate of each side, percent
  localparam int RAND_BYTES     = 1100;  // frame bytes in the random part
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
  localparam int TAIL_CYCLES    = 20;    // drain time past the last reading
  localparam int N_DIR          = 30;

  // How a directed row is checked: by the predictor alone, against a value
  // typed into the table, or for no reading at all.
  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_NO_RESULT,
    ROW_VALUE
  } row_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    row_kind_t          kind;
    logic [VALUE_W-1:0] value;
  } dir_row_t;

  // Directed bytes: a zero reading, header breaks, a full-scale reading and
  // a frame with a bad checksum.
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // reading 0*100+0, checksum -(0x18) = 0xE8
    '{8'hFF, ROW_NO_RESULT, 15'd0}, '{8'h18, ROW_NO_RESULT, 15'd0},
    '{8'h00, ROW_MODEL, 15'd0},     '{8'h00, ROW_MODEL, 15'd0},
    '{8'h00, ROW_MODEL, 15'd0},     '{8'h00, ROW_MODEL, 15'd0},
    '{8'h00, ROW_MODEL, 15'd0},     '{8'h00, ROW_MODEL, 15'd0},
    '{8'hE8, ROW_VALUE, 15'd0},
    // start, then a second start where the id belongs: it is dropped and
    // not taken as a new start, so the id that follows is a stray byte
    '{8'hFF, ROW_NO_RESULT, 15'd0}, '{8'hFF, ROW_NO_RESULT, 15'd0},
    '{8'h18, ROW_NO_RESULT, 15'd0},
    // full-scale reading 255*100+255, checksum 0xEA
    '{8'hFF, ROW_NO_RESULT, 15'd0}, '{8'h18, ROW_NO_RESULT, 15'd0},
    '{8'h00, ROW_MODEL, 15'd0},     '{8'hFF, ROW_MODEL, 15'd0},
    '{8'hFF, ROW_MODEL, 15'd0},     '{8'h00, ROW_MODEL, 15'd0},
    '{8'h00, ROW_MODEL, 15'd0},     '{8'h00, ROW_MODEL, 15'd0},
    '{8'hEA, ROW_VALUE, 15'd25755},
    // checksum off by one (0x9B would match): frame dropped
    '{8'hFF, ROW_NO_RESULT, 15'd0}, '{8'h18, ROW_NO_RESULT, 15'd0},
    '{8'h07, ROW_MODEL, 15'd0},     '{8'h12, ROW_MODEL, 15'd0},
    '{8'h34, ROW_MODEL, 15'd0},     '{8'hA5, ROW_MODEL, 15'd0},
    '{8'h5A, ROW_MODEL, 15'd0},     '{8'h01, ROW_MODEL, 15'd0},
    '{8'h9C, ROW_NO_RESULT, 15'd0}
  };

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata   = 8'h00;  // [7:0] rx_byte
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [15:0]        out_tdata;             // [14:0] pm25_value, [15] zero

  // Predictor state: a copy of the parser's frame tracking
  logic [POS_W-1:0]   frame_pos;
  logic [BYTE_W-1:0]  csum_acc;
  logic [BYTE_W-1:0]  level_hi;
  logic [BYTE_W-1:0]  level_lo;

  logic [VALUE_W-1:0] pm25_expected [$];
  int                 err_cnt      = 0;
  int                 idle_cycles  = 0;
  int                 hold_left    = 0;
  bit                 src_idle_on  = 1'b1;
  bit                 sink_idle_on = 1'b1;
  bit                 hold_req     = 1'b0;
  bit                 hold_done    = 1'b0;

  dust_sensor_frame_parser_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever begin
      #CLK_HALF clk = ~clk;
    end
  end

  task automatic clear_frame_state();
    frame_pos = POS_START;
    csum_acc  = '0;
    level_hi  = '0;
    level_lo  = '0;
  endtask

  // Advances the predicted parser by one byte; got is set when the byte
  // closes a frame whose checksum matches.
  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b, output bit got,
                               output logic [VALUE_W-1:0] value);
    logic [BYTE_W-1:0] want;
    got   = 1'b0;
    value = '0;
    if (frame_pos == POS_START) begin
      if (b == FRAME_START) begin
        frame_pos = POS_ID;
      end else begin
        clear_frame_state();
      end
    end else if (frame_pos == POS_ID) begin
      if (b == FRAME_ID) begin
        csum_acc  = b;
        frame_pos = frame_pos + POS_W'(1);
      end else begin
        clear_frame_state();
      end
    end else if (frame_pos < POS_CSUM) begin
      // payload: every byte goes into the sum, two of them are the reading
      csum_acc = csum_acc + b;
      if (frame_pos == POS_HIGH) begin
        level_hi = b;
      end else if (frame_pos == POS_LOW) begin
        level_lo = b;
      end
      frame_pos = frame_pos + POS_W'(1);
    end else if (frame_pos == POS_CSUM) begin
      want  = 8'd0 - csum_acc;
      got   = (b == want);
      value = VALUE_W'(level_hi) * VALUE_W'(HIGH_WEIGHT) + VALUE_W'(level_lo);
      clear_frame_state();
    end else begin
      clear_frame_state();
    end
  endtask

  // Offers one byte, starting and ending at a falling edge, and feeds the
  // predictor at the edge where the transaction completes.
  task automatic send_byte(input logic [BYTE_W-1:0] b, output bit got,
                           output logic [VALUE_W-1:0] value);
    while (src_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do begin
      @(posedge clk);
    end while (!in_tready);
    parse_rx_byte(b, got, value);
    if (got) begin
      pm25_expected.push_back(value);
    end
    @(negedge clk);
  endtask

  // Sends the first n_bytes of a frame with the given reading; the rest of
  // the payload is random. corrupt spoils the checksum.
  task automatic send_frame(input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo,
                            input bit corrupt, input int n_bytes);
    logic [BYTE_W-1:0]  body [9];
    logic [BYTE_W-1:0]  sum;
    logic [VALUE_W-1:0] value;
    bit                 got;
    body[0] = FRAME_START;
    body[1] = FRAME_ID;
    for (int i = 2; i < 8; i++) begin
      body[i] = 8'($urandom);
    end
    body[POS_HIGH] = hi;
    body[POS_LOW]  = lo;
    sum = '0;
    for (int i = 1; i < 8; i++) begin
      sum = sum + body[i];
    end
    body[POS_CSUM] = 8'd0 - sum;
    if (corrupt) begin
      body[POS_CSUM] = body[POS_CSUM] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < n_bytes; i++) begin
      send_byte(body[i], got, value);
    end
  endtask

  // Reading byte biased toward the ends of its range.
  function automatic logic [BYTE_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return 8'h00;
    end else if (r < 20) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  // Stray byte, often a header value so that false starts are common.
  function automatic logic [BYTE_W-1:0] pick_noise();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      return FRAME_START;
    end else if (r < 5) begin
      return FRAME_ID;
    end
    return 8'($urandom);
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left  = hold_left - 1;
      end else if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(sink_idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Reading checker: each transaction against the oldest expectation
  always @(posedge clk) begin
    logic [VALUE_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pm25_expected.size() == 0) begin
        $display("%0t: unexpected reading, actual 0x%04h", $time, out_tdata);
        err_cnt++;
      end else begin
        want = pm25_expected.pop_front();
        if (out_tdata[VALUE_W-1:0] !== want || out_tdata[15] !== 1'b0) begin
          $display("%0t: reading mismatch, expected 0x%04h actual 0x%04h",
                   $time, {1'b0, want}, out_tdata);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: no transaction on either side for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_dust_sensor_frame_parser_core: FAIL");
        $finish;
      end
    end
  end

  initial begin
    bit                 got;
    logic [VALUE_W-1:0] value;
    int                 frame_bytes;
    int                 pick;
    int                 n;

    clear_frame_state();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table; typed rows are also held against the predictor
    for (int i = 0; i < N_DIR; i++) begin
      send_byte(DIR_ROWS[i].data, got, value);
      if (DIR_ROWS[i].kind == ROW_VALUE && (!got || value !== DIR_ROWS[i].value)) begin
        $display("%0t: row %0d, expected reading %0d actual %0s %0d", $time, i,
                 DIR_ROWS[i].value, got ? "reading" : "none", value);
        err_cnt++;
      end else if (DIR_ROWS[i].kind == ROW_NO_RESULT && got) begin
        $display("%0t: row %0d, expected no reading actual %0d", $time, i, value);
        err_cnt++;
      end
    end

    // Random part: mostly whole frames, some cut short, some stray bytes
    frame_bytes = 0;
    while (frame_bytes < RAND_BYTES) begin
      // a stretch with no idling on either side
      src_idle_on  = !(frame_bytes >= 300 && frame_bytes < 600);
      sink_idle_on = src_idle_on;
      // receiver stalls for long while frames keep coming
      if (frame_bytes >= 700) begin
        hold_req = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_frame(pick_level(), pick_level(), $urandom_range(0, 99) < 15, 9);
        frame_bytes += 9;
      end else if (pick < 88) begin
        n = $urandom_range(1, 7);
        send_frame(pick_level(), pick_level(), 1'b0, n);
        frame_bytes += n;
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          send_byte(pick_noise(), got, value);
        end
        frame_bytes += n;
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then a short tail to catch stray readings
    while (pm25_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_dust_sensor_frame_parser_core: PASS");
    end else begin
      $display("tb_dust_sensor_frame_parser_core: FAIL");
    end
    $finish;
  end

endmodule
